>>> rtl/ldpclu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sequencer states for the LU systematic encoder.
package ldpclu_pkg;

    localparam int PARITY_BITS = 8;
    localparam int CODE_BITS   = 16;
    localparam int IDX_W       = $clog2(PARITY_BITS);
    localparam int COL_W       = $clog2(CODE_BITS);

    typedef logic [CODE_BITS-1:0]                     row_t;
    typedef logic [PARITY_BITS-1:0][CODE_BITS-1:0]    rows_t;
    typedef logic [PARITY_BITS-1:0][PARITY_BITS-1:0]  lu_t;
    typedef logic [PARITY_BITS-1:0]                   byte_t;
    typedef logic [IDX_W-1:0]                         idx_t;

    // Row 7 sits in the top slice, row 0 in the bottom slice.
    localparam rows_t RESET_ROWS = {
        16'h0883, 16'h1850, 16'h0031, 16'h0542,
        16'h400D, 16'h2222, 16'h2044, 16'h8B00
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP,
        ST_ELIM,
        ST_ZVEC,
        ST_FWD,
        ST_BWD,
        ST_PAR,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic load;
        logic swap;
        logic elim;
        logic zvec;
        logic fwd;
        logic bwd;
        idx_t idx;
    } ctrl_t;

endpackage

>>> rtl/ldpclu_elim.sv
`timescale 1ns / 1ps
// GF(2) elimination unit: pivot search, column swap and row reduction, one column per pass.
module ldpclu_elim (
    input  logic              aclk,
    input  ldpclu_pkg::ctrl_t ctrl,
    input  ldpclu_pkg::rows_t cfg_rows,
    output ldpclu_pkg::rows_t h_rows,
    output ldpclu_pkg::lu_t   lo_rows,
    output ldpclu_pkg::lu_t   up_rows,
    output logic              singular
);
    import ldpclu_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(CODE_BITS - 1);

    rows_t f_reg, f_next;
    rows_t h_reg, h_next;
    lu_t   lo_reg, lo_next;
    lu_t   up_reg, up_next;
    logic  singular_reg, singular_next;

    row_t              piv_row;
    logic [COL_W-1:0]  pick;
    logic [COL_W-1:0]  diag_col;
    logic [COL_W-1:0]  diag_pos;
    logic [COL_W-1:0]  pick_pos;

    function automatic row_t swap_cols(row_t row, logic [COL_W-1:0] pa, logic [COL_W-1:0] pb);
        row_t r;
        r     = row;
        r[pa] = row[pb];
        r[pb] = row[pa];
        return r;
    endfunction

    assign piv_row  = f_reg[ctrl.idx];
    assign diag_col = COL_W'(ctrl.idx);
    assign diag_pos = LAST_COL - diag_col;
    assign pick_pos = LAST_COL - pick;

    // First set column at or right of the diagonal; column 0 when none.
    always_comb begin
        pick = '0;
        for (int j = CODE_BITS - 1; j >= 0; j--) begin
            if ((COL_W'(j) >= diag_col) && piv_row[LAST_COL - COL_W'(j)]) begin
                pick = COL_W'(j);
            end
        end
    end

    always_comb begin
        f_next        = f_reg;
        h_next        = h_reg;
        lo_next       = lo_reg;
        up_next       = up_reg;
        singular_next = singular_reg;
        if (ctrl.load) begin
            f_next        = cfg_rows;
            h_next        = cfg_rows;
            singular_next = 1'b0;
        end else if (ctrl.swap) begin
            for (int r = 0; r < PARITY_BITS; r++) begin
                f_next[r] = swap_cols(f_reg[r], diag_pos, pick_pos);
                h_next[r] = swap_cols(h_reg[r], diag_pos, pick_pos);
            end
        end else if (ctrl.elim) begin
            if (!piv_row[diag_pos]) begin
                singular_next = 1'b1;
            end
            for (int r = 0; r < PARITY_BITS; r++) begin
                lo_next[r][ctrl.idx] = (IDX_W'(r) >= ctrl.idx) ? f_reg[r][diag_pos] : 1'b0;
                up_next[r][ctrl.idx] = (IDX_W'(r) <= ctrl.idx) ? f_reg[r][diag_pos] : 1'b0;
                if ((IDX_W'(r) > ctrl.idx) && f_reg[r][diag_pos]) begin
                    f_next[r] = f_reg[r] ^ piv_row;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        f_reg        <= f_next;
        h_reg        <= h_next;
        lo_reg       <= lo_next;
        up_reg       <= up_next;
        singular_reg <= singular_next;
    end

    assign h_rows   = h_reg;
    assign lo_rows  = lo_reg;
    assign up_rows  = up_reg;
    assign singular = singular_reg;

endmodule

>>> rtl/ldpclu_solve.sv
`timescale 1ns / 1ps
// Shared row solver: syndrome product, then forward and backward substitution in place.
module ldpclu_solve (
    input  logic              aclk,
    input  ldpclu_pkg::ctrl_t ctrl,
    input  ldpclu_pkg::byte_t data,
    input  ldpclu_pkg::rows_t h_rows,
    input  ldpclu_pkg::lu_t   lo_rows,
    input  ldpclu_pkg::lu_t   up_rows,
    output ldpclu_pkg::byte_t parity_byte
);
    import ldpclu_pkg::*;

    byte_t x_reg, x_next;
    byte_t coef;
    byte_t lt_mask;
    byte_t gt_mask;
    logic  term;

    // Below the diagonal for the forward pass, above it for the backward pass.
    assign lt_mask = (PARITY_BITS'(1) << ctrl.idx) - PARITY_BITS'(1);
    assign gt_mask = ~(lt_mask | (PARITY_BITS'(1) << ctrl.idx));
    assign coef    = ctrl.fwd ? (lo_rows[ctrl.idx] & lt_mask) : (up_rows[ctrl.idx] & gt_mask);
    assign term    = ^(coef & x_reg);

    always_comb begin
        x_next = x_reg;
        if (ctrl.zvec) begin
            for (int r = 0; r < PARITY_BITS; r++) begin
                x_next[r] = ^(h_rows[r][PARITY_BITS-1:0] & data);
            end
        end else if (ctrl.fwd || ctrl.bwd) begin
            x_next[ctrl.idx] = x_reg[ctrl.idx] ^ term;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
    end

    // Parity bit 0 goes out on the MSB.
    always_comb begin
        for (int k = 0; k < PARITY_BITS; k++) begin
            parity_byte[PARITY_BITS-1-k] = x_reg[k];
        end
    end

endmodule

>>> rtl/ldpc_lu_systematic_encoder_core.sv
`timescale 1ns / 1ps
// Top level: config registers, sequencer, handshake and output selection.
//
// Rate one half LDPC encoder. Each data byte taken on the s_ channel
// (s_valid/s_ready) produces two transfers on the m_ channel: first the
// parity byte, then the unchanged data byte with m_last_of_pair set.
// m_singular_flag is the same on both and marks a zero pivot.
// The 8x16 parity check matrix lives in eight 16-bit registers written
// through cfg_wr_en/cfg_index/cfg_wr_data, one register per cycle.
// Per byte the elimination unit handles 8 columns, each with a pivot
// swap, then row reduction; the solver then forms the syndrome and runs
// the forward and backward substitution passes, one row per step. The
// parity byte is offered once the backward pass has finished.
// s_ready is high only while the block is idle. A stalled receiver holds
// the current result; nothing new is taken until both results are gone.
// Reset loads the default matrix and returns the sequencer to idle.
module ldpc_lu_systematic_encoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_code_byte,
    output logic                          m_last_of_pair,
    output logic                          m_singular_flag,
    input  logic                          cfg_wr_en,
    input  logic [ldpclu_pkg::IDX_W-1:0]  cfg_index,
    input  logic [15:0]                   cfg_wr_data
);
    import ldpclu_pkg::*;

    localparam idx_t LAST_ROW = IDX_W'(PARITY_BITS - 1);

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;
    byte_t  data_reg, data_next;
    rows_t  cfg_rows_reg;
    ctrl_t  ctrl;

    rows_t  h_rows;
    lu_t    lo_rows;
    lu_t    up_rows;
    logic   singular;
    byte_t  parity_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rows_reg <= RESET_ROWS;
        end else if (cfg_wr_en) begin
            cfg_rows_reg[cfg_index] <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        ctrl       = '0;
        ctrl.idx   = idx_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    data_next  = s_data_byte;
                    idx_next   = '0;
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                ctrl.swap  = 1'b1;
                state_next = ST_ELIM;
            end
            ST_ELIM: begin
                ctrl.elim = 1'b1;
                if (idx_reg == LAST_ROW) begin
                    state_next = ST_ZVEC;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SWAP;
                end
            end
            ST_ZVEC: begin
                ctrl.zvec  = 1'b1;
                idx_next   = '0;
                state_next = ST_FWD;
            end
            ST_FWD: begin
                ctrl.fwd = 1'b1;
                if (idx_reg == LAST_ROW) begin
                    state_next = ST_BWD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_BWD: begin
                ctrl.bwd = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_PAR;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_PAR: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ldpclu_elim u_elim (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .cfg_rows (cfg_rows_reg),
        .h_rows   (h_rows),
        .lo_rows  (lo_rows),
        .up_rows  (up_rows),
        .singular (singular)
    );

    ldpclu_solve u_solve (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .data        (data_reg),
        .h_rows      (h_rows),
        .lo_rows     (lo_rows),
        .up_rows     (up_rows),
        .parity_byte (parity_byte)
    );

    assign m_code_byte     = (state_reg == ST_DATA) ? data_reg : parity_byte;
    assign m_last_of_pair  = (state_reg == ST_DATA);
    assign m_singular_flag = singular;

endmodule
